### rtl/core/endpoint_address_registry_unit_defines.svh
//------------------------------------------------------------------------------
// Endpoint address registry assertion macros
// Shared property forms for the port checker.
//------------------------------------------------------------------------------
`ifndef ENDPOINT_ADDRESS_REGISTRY_UNIT_DEFINES_SVH
`define ENDPOINT_ADDRESS_REGISTRY_UNIT_DEFINES_SVH

// same-cycle implication
`define EPAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EPAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/epar_pkg.sv
//------------------------------------------------------------------------------
// Endpoint address registry package
// Types, sizes and character codes shared by the registry modules.
//------------------------------------------------------------------------------
package epar_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 48;
    localparam int PART_W      = 32;
    localparam int ACC_W       = 17;
    localparam int ACC_MUL_W   = ACC_W + 4;
    localparam int ENTRY_W     = 11;
    localparam int FPOS_W      = 3;

    localparam logic [ACC_MUL_W-1:0] ACC_SAT   = ACC_MUL_W'(65536);
    localparam logic [ACC_W-1:0]     OCTET_MAX = ACC_W'(255);
    localparam logic [ACC_W-1:0]     PORT_MAX  = ACC_W'(65535);
    localparam logic [FPOS_W-1:0]    FPOS_PORT = FPOS_W'(3);
    localparam logic [FPOS_W-1:0]    FPOS_END  = FPOS_W'(4);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;

    typedef enum logic [2:0] {
        ST_REGISTERED = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_INVALID    = 3'd3,
        ST_FOUND      = 3'd4,
        ST_FULL       = 3'd5
    } t_status;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [ENTRY_W-1:0] entry_number;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic scan;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/epar_ram.sv
//------------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
//------------------------------------------------------------------------------
module epar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/epar_ctrl.sv
//------------------------------------------------------------------------------
// Endpoint address registry controller
// Sequences character intake, table scan and result hand-off.
//------------------------------------------------------------------------------
module epar_ctrl
    import epar_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/core/epar_dp.sv
//------------------------------------------------------------------------------
// Endpoint address registry datapath
// Address parser, key table with scan pipeline, and result register.
//------------------------------------------------------------------------------
module epar_dp
    import epar_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    input  t_in_item  i_in,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    // parse state
    logic [FPOS_W-1:0] r_fpos;
    logic [ACC_W-1:0]  r_acc;
    logic [PART_W-1:0] r_part;
    logic              r_bad;
    logic              r_op;
    logic              r_busy;
    logic              r_seen;

    logic [FPOS_W-1:0]    c_fpos;
    logic [ACC_W-1:0]     c_acc;
    logic [PART_W-1:0]    c_part;
    logic                 c_bad;
    logic                 c_seen;
    logic                 c_op;
    logic                 f_bad;
    logic [7:0]           dsub;
    logic [ACC_MUL_W-1:0] acc_ext;
    logic [ACC_MUL_W-1:0] acc_mul;
    logic                 close_ok;

    // search state
    logic [KEY_W-1:0] r_key;
    logic             r_key_bad;
    logic             r_key_op;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_issue;
    logic [CNT_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_found;
    logic [CNT_W-1:0] r_found_idx;

    logic             rd_en;
    logic [KEY_W-1:0] rd_data;
    logic             hit;
    logic             wr_en;
    logic [CNT_W-1:0] pos1;

    // result
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    always_comb begin
        c_fpos   = r_fpos;
        c_acc    = r_acc;
        c_part   = r_part;
        c_bad    = r_bad;
        c_seen   = r_seen;
        c_op     = r_busy ? r_op : i_in.operation;
        dsub     = i_in.char_code - CH_ZERO;
        acc_ext  = ACC_MUL_W'(r_acc);
        acc_mul  = (acc_ext << 3) + (acc_ext << 1) + ACC_MUL_W'(dsub[3:0]);
        close_ok = r_seen && (r_acc <= OCTET_MAX);
        if (i_in.char_code >= CH_ZERO && i_in.char_code <= CH_NINE) begin
            c_acc  = (acc_mul > ACC_SAT) ? ACC_SAT[ACC_W-1:0] : acc_mul[ACC_W-1:0];
            c_seen = 1'b1;
        end else if ((i_in.char_code == CH_DOT && r_fpos < FPOS_PORT) ||
                     (i_in.char_code == CH_COLON && r_fpos == FPOS_PORT)) begin
            c_bad  = r_bad || !close_ok;
            c_part = {r_part[PART_W-9:0], r_acc[7:0]};
            c_fpos = r_fpos + FPOS_W'(1);
            c_acc  = '0;
            c_seen = 1'b0;
        end else begin
            c_bad  = 1'b1;
        end
        f_bad = c_bad || (c_fpos != FPOS_END) || !c_seen || (c_acc > PORT_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpos <= '0;
            r_acc  <= '0;
            r_part <= '0;
            r_bad  <= 1'b0;
            r_op   <= 1'b0;
            r_busy <= 1'b0;
            r_seen <= 1'b0;
        end else if (i_cmd.take) begin
            if (i_in.last) begin
                r_fpos <= '0;
                r_acc  <= '0;
                r_part <= '0;
                r_bad  <= 1'b0;
                r_op   <= 1'b0;
                r_busy <= 1'b0;
                r_seen <= 1'b0;
            end else begin
                r_fpos <= c_fpos;
                r_acc  <= c_acc;
                r_part <= c_part;
                r_bad  <= c_bad;
                r_op   <= c_op;
                r_busy <= 1'b1;
                r_seen <= c_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_in.last) begin
            r_key <= {c_part, c_acc[15:0]};
        end
    end

    assign rd_en = i_cmd.scan && !r_key_bad && (r_issue < r_count);
    assign hit   = r_cmp_vld && (rd_data == r_key);
    assign wr_en = i_cmd.finish && !r_key_bad && (r_key_op == OP_REGISTER) && !r_found &&
                   (r_count < CNT_W'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bad <= 1'b0;
            r_key_op  <= 1'b0;
            r_issue   <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cmd.take && i_in.last) begin
                r_key_bad <= f_bad;
                r_key_op  <= c_op;
                r_issue   <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (i_cmd.scan) begin
                if (rd_en) begin
                    r_issue <= r_issue + CNT_W'(1);
                end
                r_cmp_vld <= rd_en;
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
            if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_cmp_idx <= r_issue;
            if (hit) begin
                r_found_idx <= r_cmp_idx;
            end
        end
    end

    epar_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_sts.scan_end = r_key_bad || hit || (!rd_en && !r_cmp_vld);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign pos1 = r_found_idx + CNT_W'(1);

    always_comb begin
        n_out.entry_number = '0;
        if (r_key_bad) begin
            n_out.status = ST_INVALID;
        end else if (r_key_op == OP_REGISTER) begin
            if (r_found) begin
                n_out.status = ST_DUPLICATE;
            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                n_out.status = ST_FULL;
            end else begin
                n_out.status = ST_REGISTERED;
            end
        end else if (r_found) begin
            n_out.status       = ST_FOUND;
            n_out.entry_number = ENTRY_W'(pos1);
        end else begin
            n_out.status = ST_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/endpoint_address_registry_unit.sv
// Character items are taken one per cycle while the block is idle; the final
// character of an address starts a scan of the key table at one entry per cycle
// through its single read port. The scan stops early on a match and at once for
// a malformed address.
// Synchronous active-low reset clears parse state, entry count and the output;
// the table contents stay as they are and need no clearing pass.
//------------------------------------------------------------------------------
// Endpoint address registry
// Parses a.b.c.d:port text into a 48-bit key and registers or looks it up.
//------------------------------------------------------------------------------
module endpoint_address_registry_unit
    import epar_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    epar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.last),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    epar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### rtl/core/epar_checker.sv
//------------------------------------------------------------------------------
// Endpoint address registry port checker
// Watches the top-level ports for result consistency and output stability.
//------------------------------------------------------------------------------
`include "endpoint_address_registry_unit_defines.svh"

module epar_checker
    import epar_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    `EPAR_ASSERT_IMP(a_entry_iff_found, i_clk, i_rst_n, o_out_valid, ((o_out.status == ST_FOUND) == (o_out.entry_number != '0)), "entry number disagrees with status")
    `EPAR_ASSERT_IMP(a_entry_in_range, i_clk, i_rst_n, o_out_valid, (o_out.entry_number <= ENTRY_W'(TABLE_DEPTH)), "entry number beyond table")
    `EPAR_ASSERT_NXT(a_no_result_mid_addr, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_in.last, !$rose(o_out_valid), "result without final character")
    `EPAR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

endmodule

bind endpoint_address_registry_unit epar_checker u_epar_checker (.*);

### tb/sv/endpoint_address_registry_unit_tb.sv
//------------------------------------------------------------------------------
// Endpoint address registry testbench
// Streams a.b.c.d:port text into the registry one character per item,
// well-formed and malformed, and checks every status and entry number
// against a predictor that keeps its own key table. A long receiver
// hold-off backs the block up into its input.
//------------------------------------------------------------------------------
module endpoint_address_registry_unit_tb
    import epar_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned PHASE_CHARS = 585;
    localparam int unsigned DRAIN_CYCLES = 1100;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef enum int {
        K_CLEAN,
        K_OCTET_BIG,
        K_PORT_BIG,
        K_EMPTY,
        K_MISPLACED,
        K_EXTRA_SEP,
        K_TRUNC,
        K_BAD_CHAR,
        K_NOISE
    } t_kind;

    class registry_scoreboard;
        bit [KEY_W-1:0]  key_store [TABLE_DEPTH];
        int unsigned     n_keys;
        bit [FPOS_W-1:0] fpos;
        bit [ACC_W-1:0]  acc;
        bit [KEY_W-1:0]  part_key;
        bit              bad;
        bit              held_op;
        bit              busy;
        bit              seen;
        t_out_item       status_due[$];
        int unsigned     n_mismatch;

        function new();
            n_keys = 0;
            n_mismatch = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            fpos = '0;
            acc = '0;
            part_key = '0;
            bad = 1'b0;
            held_op = 1'b0;
            busy = 1'b0;
            seen = 1'b0;
        endfunction

        function void close_field();
            if (!seen || acc > OCTET_MAX) begin
                bad = 1'b1;
            end
            part_key = {part_key[KEY_W-9:0], acc[7:0]};
            fpos++;
            acc = '0;
            seen = 1'b0;
        endfunction

        function void note_char(t_in_item it);
            bit [KEY_W-1:0] key;
            int             hit;
            int unsigned    v;
            t_out_item      res;
            if (!busy) begin
                held_op = it.operation;
                busy = 1'b1;
            end
            if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
                v = 32'(acc) * 32'd10 + 32'(it.char_code - CH_ZERO);
                acc = (v > 32'(ACC_SAT)) ? ACC_W'(ACC_SAT) : ACC_W'(v);
                seen = 1'b1;
            end else if (it.char_code == CH_DOT) begin
                if (fpos < FPOS_PORT) close_field();
                else bad = 1'b1;
            end else if (it.char_code == CH_COLON) begin
                if (fpos == FPOS_PORT) close_field();
                else bad = 1'b1;
            end else begin
                bad = 1'b1;
            end
            if (!it.last) return;

            if (fpos != FPOS_END || !seen || acc > PORT_MAX) begin
                bad = 1'b1;
            end
            key = {part_key[31:0], acc[15:0]};
            res.entry_number = '0;
            if (bad) begin
                res.status = ST_INVALID;
            end else begin
                hit = -1;
                for (int i = 0; i < n_keys; i++) begin
                    if (key_store[i] == key) begin
                        hit = i;
                        break;
                    end
                end
                if (held_op == OP_REGISTER) begin
                    if (hit >= 0) begin
                        res.status = ST_DUPLICATE;
                    end else if (n_keys >= TABLE_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        key_store[n_keys] = key;
                        n_keys++;
                        res.status = ST_REGISTERED;
                    end
                end else if (hit >= 0) begin
                    res.status = ST_FOUND;
                    res.entry_number = ENTRY_W'(hit + 1);
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            status_due.push_back(res);
            clear_parse();
        endfunction

        function void check_status(t_out_item got);
            t_out_item want;
            if (status_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("unexpected result: status %0d entry %0d",
                             got.status, got.entry_number);
                end
                return;
            end
            want = status_due.pop_front();
            if (got.status !== want.status || got.entry_number !== want.entry_number) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("mismatch: expected status %0d entry %0d, got status %0d entry %0d",
                             want.status, want.entry_number, got.status, got.entry_number);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    registry_scoreboard sb;
    logic [7:0]         addr_text[$];
    bit [KEY_W-1:0]     key_pool[$];
    int unsigned        tx_idle_pct = 0;
    int unsigned        rx_idle_pct = 0;
    int unsigned        n_chars = 0;
    int unsigned        cycles = 0;
    bit                 pressure_go = 1'b0;
    bit                 pressure_done = 1'b0;

    endpoint_address_registry_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (pressure_go && !pressure_done) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_status(o_out);
        end
    end

    // hold the result side off so the block backs up into its input
    initial begin
        wait (pressure_go);
        repeat (HOLD_CYCLES) @(negedge i_clk);
        pressure_done = 1'b1;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("endpoint_address_registry_unit_tb: done, errors");
        $finish;
    end

    function automatic void put_num(int unsigned v, int unsigned pad);
        string d;
        d = $sformatf("%0d", v);
        repeat (pad) addr_text.push_back(CH_ZERO);
        for (int i = 0; i < d.len(); i++) begin
            addr_text.push_back(d[i]);
        end
    endfunction

    function automatic void put_clean(bit [KEY_W-1:0] key);
        addr_text.delete();
        for (int f = 0; f < 4; f++) begin
            put_num(32'(key[KEY_W-1-8*f -: 8]), 0);
            addr_text.push_back((f == 3) ? CH_COLON : CH_DOT);
        end
        put_num(32'(key[15:0]), 0);
    endfunction

    task automatic make_random_addr();
        t_kind          kind;
        int unsigned    r;
        int unsigned    bad_f;
        bit [KEY_W-1:0] key;
        bit             big_here;
        r = $urandom_range(99);
        kind = (r < 60) ? K_CLEAN : (r < 65) ? K_OCTET_BIG : (r < 70) ? K_PORT_BIG :
               (r < 74) ? K_EMPTY : (r < 79) ? K_MISPLACED : (r < 83) ? K_EXTRA_SEP :
               (r < 88) ? K_TRUNC : (r < 94) ? K_BAD_CHAR : K_NOISE;
        addr_text.delete();
        if (kind == K_NOISE) begin
            repeat ($urandom_range(1, 6)) addr_text.push_back(8'($urandom_range(255)));
            return;
        end

        if (key_pool.size() != 0 && $urandom_range(1) == 1) begin
            key = key_pool[$urandom_range(key_pool.size() - 1)];
        end else begin
            for (int f = 0; f < 4; f++) begin
                r = $urandom_range(9);
                key[KEY_W-1-8*f -: 8] = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                                        8'($urandom_range(255));
            end
            r = $urandom_range(9);
            key[15:0] = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(65535));
            if (kind == K_CLEAN) key_pool.push_back(key);
        end

        bad_f = $urandom_range(4);
        if (kind == K_PORT_BIG) bad_f = 4;
        if ((kind == K_OCTET_BIG || kind == K_MISPLACED) && bad_f == 4) begin
            bad_f = $urandom_range(3);
        end

        for (int f = 0; f < 5; f++) begin
            big_here = (kind == K_OCTET_BIG || kind == K_PORT_BIG) && f == bad_f;
            if (big_here) begin
                r = $urandom_range(2);
                if (r == 0) begin
                    put_num((f == 4) ? 65536 : 256, 0);
                end else if (r == 1) begin
                    put_num((f == 4) ? $urandom_range(65536, 99999) : $urandom_range(256, 999), 0);
                end else begin
                    addr_text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                    repeat ($urandom_range((f == 4) ? 5 : 3, 11)) begin
                        addr_text.push_back(CH_ZERO + 8'($urandom_range(9)));
                    end
                end
            end else if (!(kind == K_EMPTY && f == bad_f)) begin
                put_num((f < 4) ? 32'(key[KEY_W-1-8*f -: 8]) : 32'(key[15:0]),
                        ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
            end
            if (f < 4) begin
                addr_text.push_back(((f == 3) != (kind == K_MISPLACED && f == bad_f)) ?
                                    CH_COLON : CH_DOT);
            end
        end

        case (kind)
            K_TRUNC: begin
                r = $urandom_range(1, addr_text.size() - 1);
                while (addr_text.size() > r) void'(addr_text.pop_back());
            end
            K_BAD_CHAR: begin
                addr_text[$urandom_range(addr_text.size() - 1)] = 8'($urandom_range(255));
            end
            K_EXTRA_SEP: begin
                addr_text.insert($urandom_range(addr_text.size()),
                                 ($urandom_range(1) == 1) ? CH_DOT : CH_COLON);
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_addr(logic op);
        t_in_item it;
        for (int i = 0; i < addr_text.size(); i++) begin
            it.operation = (i == 0) ? op : 1'($urandom_range(1));
            it.char_code = addr_text[i];
            it.last = (i == addr_text.size() - 1);
            if ($urandom_range(99) < tx_idle_pct) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while ($urandom_range(99) < tx_idle_pct);
            end
            i_in_valid <= 1'b1;
            i_in <= it;
            do @(posedge i_clk); while (!o_in_ready);
            sb.note_char(it);
            n_chars++;
            @(negedge i_clk);
        end
    endtask

    initial begin
        int unsigned target;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 33;
        rx_idle_pct = 51;
        put_clean('0);
        send_addr(OP_REGISTER);
        send_addr(OP_LOOKUP);
        addr_text.delete();
        addr_text.push_back(8'hFF);
        send_addr(OP_LOOKUP);
        addr_text.delete();
        addr_text.push_back(8'h00);
        send_addr(OP_REGISTER);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 51 : 0;
            rx_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 33 : 0;
            if (ph == 2) pressure_go = 1'b1;
            target = n_chars + PHASE_CHARS;
            while (n_chars < target) begin
                make_random_addr();
                send_addr(1'($urandom_range(1)));
            end
        end

        put_clean('0);
        send_addr(OP_LOOKUP);
        i_in_valid <= 1'b0;

        while (sb.status_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_mismatch == 0 && sb.status_due.size() == 0) begin
            $display("endpoint_address_registry_unit_tb: done, clean");
        end else begin
            $display("endpoint_address_registry_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
